FILE: rtl/sra_pkg.sv
// Shared types and codes for the skyline rectangle allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package sra_pkg;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SHRINK = 2'd3;

  // datapath micro-operations, one per controller state
  typedef enum logic [4:0] {
    CMD_CLEAR,
    CMD_IDLE,
    CMD_START,
    CMD_GR0,
    CMD_GR1,
    CMD_GR2,
    CMD_GR3,
    CMD_INS0,
    CMD_OUT,
    CMD_INN,
    CMD_ACC,
    CMD_EVAL,
    CMD_FIN,
    CMD_PLK,
    CMD_RLS,
    CMD_ALC0,
    CMD_ALC1,
    CMD_LINK,
    CMD_MA0,
    CMD_MA1,
    CMD_MB,
    CMD_MB1,
    CMD_DONE
  } cmd_e;

  // decision flags from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_ins;
    logic shrink;
    logic same;
    logic nx_ok;
    logic g_ext;
    logic free_ok;
    logic zero;
    logic out_go;
    logic inn_go;
    logic found;
    logic bp_end;
    logic rls_cond;
    logic first;
    logic it_ok;
    logic ma;
    logic mb;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/sra_in_if.sv
// Request channel of the skyline rectangle allocator: op and size fields.
// No dependencies.
`default_nettype none
interface sra_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] size_x;
  logic [15:0] size_y;

  modport source (output valid, op, size_x, size_y, input ready);
  modport sink (input valid, op, size_x, size_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/sra_out_if.sv
// Response channel of the skyline rectangle allocator: placement and status.
// No dependencies.
`default_nettype none
interface sra_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] place_x;
  logic [15:0] place_y;
  logic [1:0]  status;

  modport source (output valid, place_x, place_y, status, input ready);
  modport sink (input valid, place_x, place_y, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/sra_ctrl.sv
// Sequencer of the skyline allocator: one-hot state machine issuing datapath commands.
// Depends on sra_pkg.
`default_nettype none
module sra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            load_o,
  input  sra_pkg::sts_t   sts_i,
  output sra_pkg::cmd_e   cmd_o
);
  import sra_pkg::*;

  typedef enum logic [22:0] {
    S_CLEAR = 23'd1 << 0,
    S_IDLE  = 23'd1 << 1,
    S_START = 23'd1 << 2,
    S_GR0   = 23'd1 << 3,
    S_GR1   = 23'd1 << 4,
    S_GR2   = 23'd1 << 5,
    S_GR3   = 23'd1 << 6,
    S_INS0  = 23'd1 << 7,
    S_OUT   = 23'd1 << 8,
    S_INN   = 23'd1 << 9,
    S_ACC   = 23'd1 << 10,
    S_EVAL  = 23'd1 << 11,
    S_FIN   = 23'd1 << 12,
    S_PLK   = 23'd1 << 13,
    S_RLS   = 23'd1 << 14,
    S_ALC0  = 23'd1 << 15,
    S_ALC1  = 23'd1 << 16,
    S_LINK  = 23'd1 << 17,
    S_MA0   = 23'd1 << 18,
    S_MA1   = 23'd1 << 19,
    S_MB    = 23'd1 << 20,
    S_MB1   = 23'd1 << 21,
    S_DONE  = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign load_o     = (state_q == S_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_IDLE;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o = CMD_IDLE;
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        cmd_o   = CMD_START;
        state_d = sts_i.is_ins ? S_INS0 : S_GR0;
      end
      S_GR0: begin
        cmd_o   = CMD_GR0;
        state_d = (sts_i.shrink || sts_i.same) ? S_DONE : S_GR1;
      end
      S_GR1: begin
        cmd_o = CMD_GR1;
        if (sts_i.nx_ok) state_d = S_GR1;
        else if (sts_i.g_ext || !sts_i.free_ok) state_d = S_DONE;
        else state_d = S_GR2;
      end
      S_GR2: begin
        cmd_o   = CMD_GR2;
        state_d = S_GR3;
      end
      S_GR3: begin
        cmd_o   = CMD_GR3;
        state_d = S_DONE;
      end
      S_INS0: begin
        cmd_o   = CMD_INS0;
        state_d = sts_i.zero ? S_DONE : S_OUT;
      end
      S_OUT: begin
        cmd_o   = CMD_OUT;
        state_d = sts_i.out_go ? S_INN : S_FIN;
      end
      S_INN: begin
        cmd_o   = CMD_INN;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o   = CMD_ACC;
        state_d = sts_i.inn_go ? S_INN : S_EVAL;
      end
      S_EVAL: begin
        cmd_o   = CMD_EVAL;
        state_d = S_OUT;
      end
      S_FIN: begin
        cmd_o = CMD_FIN;
        if (!sts_i.found) state_d = S_DONE;
        else if (sts_i.bp_end) state_d = S_RLS;
        else state_d = S_PLK;
      end
      S_PLK: begin
        cmd_o   = CMD_PLK;
        state_d = S_RLS;
      end
      S_RLS: begin
        cmd_o = CMD_RLS;
        if (sts_i.rls_cond) state_d = sts_i.nx_ok ? S_RLS : S_ALC0;
        else if (sts_i.first && !sts_i.free_ok) state_d = S_DONE;
        else state_d = S_ALC0;
      end
      S_ALC0: begin
        cmd_o   = CMD_ALC0;
        state_d = S_ALC1;
      end
      S_ALC1: begin
        cmd_o   = CMD_ALC1;
        state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o   = CMD_LINK;
        state_d = sts_i.it_ok ? S_MA0 : S_MB;
      end
      S_MA0: begin
        cmd_o   = CMD_MA0;
        state_d = sts_i.ma ? S_MA1 : S_MB;
      end
      S_MA1: begin
        cmd_o   = CMD_MA1;
        state_d = S_MB;
      end
      S_MB: begin
        cmd_o   = CMD_MB;
        state_d = sts_i.mb ? S_MB1 : S_DONE;
      end
      S_MB1: begin
        cmd_o   = CMD_MB1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o = CMD_DONE;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        cmd_o   = CMD_IDLE;
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sra_dp.sv
// Datapath of the skyline allocator: segment memory, walk registers, cost unit, output reg.
// Depends on sra_pkg; driven by sra_ctrl commands.
`default_nettype none
module sra_dp #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sra_pkg::cmd_e cmd_i,
  input  logic          load_i,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_op_i,
  input  logic [15:0]   in_size_x_i,
  input  logic [15:0]   in_size_y_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [15:0]   out_place_x_o,
  output logic [15:0]   out_place_y_o,
  output logic [1:0]    out_status_o,
  output sra_pkg::sts_t sts_o
);
  import sra_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int IW = AW + 1;
  localparam int CW = COORD_BITS;
  localparam int XW = CW + 1;
  localparam int KW = 2 * CW + 1;
  localparam logic [IW-1:0] SEG_END = IW'(MAX_SEGMENTS);

  function automatic logic is_ok(input logic [IW-1:0] idx);
    return idx < SEG_END;
  endfunction

  // segment pool
  logic [CW-1:0] mem_wd  [MAX_SEGMENTS];
  logic [CW-1:0] mem_alt [MAX_SEGMENTS];
  logic [IW-1:0] mem_nx  [MAX_SEGMENTS];
  logic [CW-1:0] rd_wd_q, rd_alt_q;
  logic [IW-1:0] rd_nx_q;
  logic          re;
  logic [IW-1:0] ra;
  logic          we_wd, we_alt, we_nx;
  logic [IW-1:0] wa;
  logic [CW-1:0] wdat_wd, wdat_alt;
  logic [IW-1:0] wdat_nx;

  // control state
  logic [AW-1:0] clr_q, clr_d;
  logic          tb_q, tb_d;
  logic [CW-1:0] pw_q, pw_d, ph_q, ph_d;
  logic [IW-1:0] sky_q, sky_d, free_q, free_d;
  logic          first_q, first_d, found_q, found_d;
  logic          ovalid_q, ovalid_d;

  // walk payload
  logic          op_q, op_d;
  logic [CW-1:0] w_q, w_d, h_q, h_d;
  logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, it_q, it_d, curnx_q, curnx_d;
  logic [IW-1:0] bprev_q, bprev_d, ns_q, ns_d, nsnx_q, nsnx_d;
  logic [XW-1:0] curx_q, curx_d, ix_q, ix_d, bx_q, bx_d;
  logic [CW-1:0] ia_q, ia_d, ma_q, ma_d, mb_q, mb_d, curwd_q, curwd_d;
  logic [CW-1:0] balt_q, balt_d, bpwd_q, bpwd_d, bpalt_q, bpalt_d, nswd_q, nswd_d;
  logic [KW-1:0] cost_q, cost_d, bcost_q, bcost_d;
  logic [1:0]    res_st_q, res_st_d, ost_q, ost_d;
  logic [15:0]   res_px_q, res_px_d, res_py_q, res_py_d;
  logic [15:0]   opx_q, opx_d, opy_q, opy_d;

  // derived values
  logic [XW-1:0]   endc, bend, occ_diff, ixw;
  logic [CW-1:0]   occ, ia_eff, na;
  logic [2*CW-1:0] prod;
  logic            better;

  assign endc     = curx_q + XW'(w_q);
  assign bend     = bx_q + XW'(w_q);
  assign occ_diff = endc - ix_q;
  assign occ      = (occ_diff < XW'(rd_wd_q)) ? CW'(occ_diff) : rd_wd_q;
  assign ia_eff   = first_q ? rd_alt_q : ia_q;
  assign na       = balt_q + h_q;
  assign prod     = ma_q * mb_q;
  assign ixw      = ix_q + XW'(rd_wd_q);
  assign better   = (ix_q >= endc) && ((XW'(ia_q) + XW'(h_q)) <= XW'(ph_q)) &&
                    (!found_q || (ia_q < balt_q) ||
                     (tb_q && (ia_q == balt_q) && (cost_q < bcost_q)));

  always_comb begin
    sts_o.clr_last = (clr_q == AW'(MAX_SEGMENTS - 1));
    sts_o.is_ins   = op_q;
    sts_o.shrink   = (w_q < pw_q) || (h_q < ph_q);
    sts_o.same     = (w_q == pw_q);
    sts_o.nx_ok    = is_ok(rd_nx_q);
    sts_o.g_ext    = (rd_alt_q == '0);
    sts_o.free_ok  = is_ok(free_q);
    sts_o.zero     = (w_q == '0) || (h_q == '0);
    sts_o.out_go   = is_ok(cur_q) && (endc <= XW'(pw_q));
    sts_o.inn_go   = (ix_q < endc) && is_ok(it_q);
    sts_o.found    = found_q;
    sts_o.bp_end   = (bprev_q == SEG_END);
    sts_o.rls_cond = (ixw <= bend);
    sts_o.first    = first_q;
    sts_o.it_ok    = is_ok(it_q);
    sts_o.ma       = (rd_alt_q == na);
    sts_o.mb       = (bx_q != '0) && (bprev_q != SEG_END) && (bpalt_q == na);
    sts_o.out_free = !ovalid_q || out_ready_i;
  end

  always_comb begin
    clr_d = clr_q;  tb_d = tb_q;  pw_d = pw_q;  ph_d = ph_q;
    sky_d = sky_q;  free_d = free_q;  first_d = first_q;  found_d = found_q;
    ovalid_d = ovalid_q;
    op_d = op_q;  w_d = w_q;  h_d = h_q;
    cur_d = cur_q;  prev_d = prev_q;  it_d = it_q;  curnx_d = curnx_q;
    bprev_d = bprev_q;  ns_d = ns_q;  nsnx_d = nsnx_q;
    curx_d = curx_q;  ix_d = ix_q;  bx_d = bx_q;
    ia_d = ia_q;  ma_d = ma_q;  mb_d = mb_q;  curwd_d = curwd_q;
    balt_d = balt_q;  bpwd_d = bpwd_q;  bpalt_d = bpalt_q;  nswd_d = nswd_q;
    cost_d = cost_q;  bcost_d = bcost_q;
    res_st_d = res_st_q;  res_px_d = res_px_q;  res_py_d = res_py_q;
    ost_d = ost_q;  opx_d = opx_q;  opy_d = opy_q;
    re = 1'b0;  ra = it_q;
    we_wd = 1'b0;  we_alt = 1'b0;  we_nx = 1'b0;  wa = it_q;
    wdat_wd = '0;  wdat_alt = '0;  wdat_nx = SEG_END;

    if (cfg_we_i) tb_d = cfg_wdata_i;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (cmd_i)
      CMD_CLEAR: begin
        we_wd = 1'b1;  we_alt = 1'b1;  we_nx = 1'b1;
        wa    = IW'(clr_q);
        if (clr_q != '0 && !sts_o.clr_last) wdat_nx = IW'(clr_q) + IW'(1);
        clr_d = clr_q + AW'(1);
      end
      CMD_IDLE: begin
        if (load_i) begin
          op_d     = in_op_i;
          w_d      = CW'(in_size_x_i);
          h_d      = CW'(in_size_y_i);
          res_px_d = '0;
          res_py_d = '0;
        end
      end
      CMD_START: begin
      end
      CMD_GR0: begin
        if (sts_o.shrink) begin
          res_st_d = ST_SHRINK;
        end else if (sts_o.same) begin
          ph_d = h_q;  res_st_d = ST_DONE;
        end else begin
          it_d = sky_q;  re = 1'b1;  ra = sky_q;
        end
      end
      CMD_GR1: begin
        if (sts_o.nx_ok) begin
          // advance toward the tail
          it_d = rd_nx_q;  re = 1'b1;  ra = rd_nx_q;
        end else if (sts_o.g_ext) begin
          we_wd   = 1'b1;
          wdat_wd = rd_wd_q + (w_q - pw_q);
          pw_d = w_q;  ph_d = h_q;  res_st_d = ST_DONE;
        end else if (!sts_o.free_ok) begin
          res_st_d = ST_FULL;
        end else begin
          ns_d = free_q;  re = 1'b1;  ra = free_q;
        end
      end
      CMD_GR2: begin
        we_wd = 1'b1;  we_alt = 1'b1;  we_nx = 1'b1;  wa = ns_q;
        wdat_wd = w_q - pw_q;
        free_d  = rd_nx_q;
      end
      CMD_GR3: begin
        we_nx = 1'b1;  wdat_nx = ns_q;
        pw_d = w_q;  ph_d = h_q;  res_st_d = ST_DONE;
      end
      CMD_INS0: begin
        if (sts_o.zero) begin
          res_st_d = ST_NOFIT;
        end else begin
          found_d = 1'b0;  prev_d = SEG_END;  cur_d = sky_q;  curx_d = '0;
        end
      end
      CMD_OUT: begin
        if (sts_o.out_go) begin
          it_d = cur_q;  ix_d = curx_q;  cost_d = '0;  first_d = 1'b1;
          re = 1'b1;  ra = cur_q;
        end
      end
      CMD_INN: begin
        if (first_q) begin
          curwd_d = rd_wd_q;  curnx_d = rd_nx_q;
        end
        if (ia_eff < rd_alt_q) begin
          // step up: everything left of this segment under the rectangle is wasted
          ma_d = CW'(ix_q - curx_q);  mb_d = rd_alt_q - ia_eff;  ia_d = rd_alt_q;
        end else begin
          ma_d = occ;  mb_d = ia_eff - rd_alt_q;  ia_d = ia_eff;
        end
        ix_d = ixw;  it_d = rd_nx_q;  first_d = 1'b0;
      end
      CMD_ACC: begin
        cost_d = cost_q + KW'(prod);
        if (sts_o.inn_go) begin
          re = 1'b1;  ra = it_q;
        end
      end
      CMD_EVAL: begin
        if (better) begin
          found_d = 1'b1;  bprev_d = prev_q;  bx_d = curx_q;
          balt_d = ia_q;  bcost_d = cost_q;
        end
        curx_d = curx_q + XW'(curwd_q);  prev_d = cur_q;  cur_d = curnx_q;
      end
      CMD_FIN: begin
        if (!found_q) begin
          res_st_d = ST_NOFIT;
        end else begin
          ix_d = bx_q;  first_d = 1'b1;
          if (sts_o.bp_end) begin
            it_d = sky_q;  re = 1'b1;  ra = sky_q;
          end else begin
            re = 1'b1;  ra = bprev_q;
          end
        end
      end
      CMD_PLK: begin
        bpwd_d = rd_wd_q;  bpalt_d = rd_alt_q;  it_d = rd_nx_q;
        re = 1'b1;  ra = rd_nx_q;
      end
      CMD_RLS: begin
        if (sts_o.rls_cond) begin
          // fully covered: drop the segment onto the free list
          we_nx = 1'b1;  wdat_nx = free_q;
          free_d = it_q;  ix_d = ixw;  it_d = rd_nx_q;  first_d = 1'b0;
          if (sts_o.nx_ok) begin
            re = 1'b1;  ra = rd_nx_q;
          end
        end else if (first_q && !sts_o.free_ok) begin
          res_st_d = ST_FULL;
        end else if (ix_q != bend) begin
          we_wd = 1'b1;  wdat_wd = CW'(ixw - bend);
        end
      end
      CMD_ALC0: begin
        ns_d = free_q;  re = 1'b1;  ra = free_q;
      end
      CMD_ALC1: begin
        free_d = rd_nx_q;
        we_wd = 1'b1;  we_alt = 1'b1;  we_nx = 1'b1;  wa = ns_q;
        wdat_wd = w_q;  wdat_alt = na;  wdat_nx = it_q;
        nswd_d = w_q;  nsnx_d = it_q;
      end
      CMD_LINK: begin
        if (sts_o.bp_end) begin
          sky_d = ns_q;
        end else begin
          we_nx = 1'b1;  wa = bprev_q;  wdat_nx = ns_q;
        end
        if (sts_o.it_ok) begin
          re = 1'b1;  ra = it_q;
        end
      end
      CMD_MA0: begin
        if (sts_o.ma) begin
          nswd_d = nswd_q + rd_wd_q;  nsnx_d = rd_nx_q;
          we_wd = 1'b1;  we_nx = 1'b1;  wa = ns_q;
          wdat_wd = nswd_q + rd_wd_q;  wdat_nx = rd_nx_q;
        end
      end
      CMD_MA1: begin
        we_nx = 1'b1;  wdat_nx = free_q;  free_d = it_q;
      end
      CMD_MB: begin
        if (sts_o.mb) begin
          we_wd = 1'b1;  we_nx = 1'b1;  wa = bprev_q;
          wdat_wd = bpwd_q + nswd_q;  wdat_nx = nsnx_q;
        end else begin
          res_st_d = ST_DONE;  res_px_d = 16'(bx_q);  res_py_d = 16'(balt_q);
        end
      end
      CMD_MB1: begin
        we_nx = 1'b1;  wa = ns_q;  wdat_nx = free_q;  free_d = ns_q;
        res_st_d = ST_DONE;  res_px_d = 16'(bx_q);  res_py_d = 16'(balt_q);
      end
      CMD_DONE: begin
        if (sts_o.out_free) begin
          ovalid_d = 1'b1;  ost_d = res_st_q;  opx_d = res_px_q;  opy_d = res_py_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_wd)  mem_wd[wa[AW-1:0]]  <= wdat_wd;
    if (we_alt) mem_alt[wa[AW-1:0]] <= wdat_alt;
    if (we_nx)  mem_nx[wa[AW-1:0]]  <= wdat_nx;
    if (re) begin
      rd_wd_q  <= mem_wd[ra[AW-1:0]];
      rd_alt_q <= mem_alt[ra[AW-1:0]];
      rd_nx_q  <= mem_nx[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      tb_q     <= 1'b0;
      pw_q     <= '0;
      ph_q     <= '0;
      sky_q    <= '0;
      free_q   <= IW'(1);
      first_q  <= 1'b0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      clr_q    <= clr_d;
      tb_q     <= tb_d;
      pw_q     <= pw_d;
      ph_q     <= ph_d;
      sky_q    <= sky_d;
      free_q   <= free_d;
      first_q  <= first_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  w_q <= w_d;  h_q <= h_d;
    cur_q <= cur_d;  prev_q <= prev_d;  it_q <= it_d;  curnx_q <= curnx_d;
    bprev_q <= bprev_d;  ns_q <= ns_d;  nsnx_q <= nsnx_d;
    curx_q <= curx_d;  ix_q <= ix_d;  bx_q <= bx_d;
    ia_q <= ia_d;  ma_q <= ma_d;  mb_q <= mb_d;  curwd_q <= curwd_d;
    balt_q <= balt_d;  bpwd_q <= bpwd_d;  bpalt_q <= bpalt_d;  nswd_q <= nswd_d;
    cost_q <= cost_d;  bcost_q <= bcost_d;
    res_st_q <= res_st_d;  res_px_q <= res_px_d;  res_py_q <= res_py_d;
    ost_q <= ost_d;  opx_q <= opx_d;  opy_q <= opy_d;
  end

  assign out_valid_o   = ovalid_q;
  assign out_place_x_o = opx_q;
  assign out_place_y_o = opy_q;
  assign out_status_o  = ost_q;

  a_sky_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sky_q < SEG_END) else $error("skyline head points outside the pool");

  // between requests the skyline head and the free list head differ
  a_lists_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_IDLE) |-> (sky_q != free_q))
    else $error("skyline and free list share a head");

  a_width_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pw_q >= $past(pw_q)) else $error("packing width decreased");

endmodule
`default_nettype wire

FILE: rtl/skyline_rect_allocator_top.sv
// Skyline rectangle allocator: bottom-left rectangle packing over a segment list.
// Channels req_i (op, size_x, size_y) and rsp_o (place_x, place_y, status), each a
// valid/ready transfer; a single-bit tiebreak register written through cfg_we_i.
// After reset the block sweeps all MAX_SEGMENTS entries of the segment pool to
// build the free chain with req_i.ready low; config writes are taken throughout.
// One request is worked at a time. A grow that widens the area walks the segment
// list to reach the tail. An insert walks the segments covered at every candidate
// start, then rewrites the list and frees each fully covered segment; the pace of
// both is set by the segment memory, which has one write port and one registered
// read port. Each response sits in an output register: a new request is taken while
// the previous response waits, and if the receiver stalls the next response holds
// the sequencer until the register frees.
// Depends on sra_pkg, sra_in_if, sra_out_if, sra_ctrl and sra_dp.
`default_nettype none
module skyline_rect_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sra_in_if.sink    req_i,
  sra_out_if.source rsp_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);
  import sra_pkg::*;

  cmd_e cmd;
  sts_t sts;
  logic load;

  sra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .load_o     (load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sra_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .load_i        (load),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (req_i.op),
    .in_size_x_i   (req_i.size_x),
    .in_size_y_i   (req_i.size_y),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_place_x_o (rsp_o.place_x),
    .out_place_y_o (rsp_o.place_y),
    .out_status_o  (rsp_o.status),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire
